FILE: rtl/sfb_pkg.sv
`timescale 1ns / 1ps

package sfb_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int CFG_IDX_W = 8;

    localparam logic OP_HEADER = 1'b0;
    localparam logic OP_DATA = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_ID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER = CFG_IDX_W'(1);

    localparam logic [7:0] SEQ_REQ_FLAG = 8'h80;
    localparam logic [6:0] REQ_NUM_MAX = 7'h7f;
    localparam logic [6:0] REQ_NUM_FIRST = 7'd1;

    typedef struct packed {
        logic       is_hdr;
        logic [7:0] cmd;
        logic [7:0] seq_byte;
        logic [7:0] b3;
        logic       close;
        logic [6:0] seq7;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd entry;
    } t_push;

    typedef struct packed {
        logic valid;
        logic full;
    } t_qstat;

endpackage

FILE: rtl/sfb_ifs.sv
`timescale 1ns / 1ps

interface sfb_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic       is_request;
    logic [6:0] reply_number;
    logic [7:0] command;
    logic [7:0] data_length;
    logic [7:0] data_byte;

    modport source (output valid, output operation, output is_request, output reply_number,
                    output command, output data_length, output data_byte, input ready);
    modport sink (input valid, input operation, input is_request, input reply_number,
                  input command, input data_length, input data_byte, output ready);
endinterface

interface sfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       run_last;
    logic       frame_last;
    logic [6:0] request_number;

    modport source (output valid, output frame_byte, output run_last, output frame_last,
                    output request_number, input ready);
    modport sink (input valid, input frame_byte, input run_last, input frame_last,
                  input request_number, output ready);
endinterface

interface sfb_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [sfb_pkg::CFG_IDX_W-1:0] index;
    logic [7:0]                    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/sfb_front.sv
`timescale 1ns / 1ps

module sfb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfb_in_if.sink          i_in,
    input  sfb_pkg::t_qstat i_qstat,
    output sfb_pkg::t_push  o_push
);

    logic [6:0] r_next_req;
    logic [7:0] r_remaining;
    logic       r_open;
    logic [6:0] r_frame_seq;

    logic [6:0] n_next_req;
    logic [7:0] n_remaining;
    logic       n_open;
    logic [6:0] n_frame_seq;

    logic       accept;
    logic [7:0] seq_byte;

    assign i_in.ready = !i_qstat.full;
    assign accept = i_in.valid && i_in.ready;

    always_comb begin
        n_next_req = r_next_req;
        n_remaining = r_remaining;
        n_open = r_open;
        n_frame_seq = r_frame_seq;
        seq_byte = {1'b0, i_in.reply_number};
        o_push = '0;
        if (i_in.is_request) begin
            seq_byte = sfb_pkg::SEQ_REQ_FLAG | {1'b0, r_next_req};
        end
        if (accept) begin
            if (i_in.operation == sfb_pkg::OP_HEADER) begin
                if (i_in.is_request) begin
                    n_next_req = (r_next_req == sfb_pkg::REQ_NUM_MAX) ?
                                 sfb_pkg::REQ_NUM_FIRST : r_next_req + 7'd1;
                end
                n_frame_seq = seq_byte[6:0];
                n_remaining = i_in.data_length;
                n_open = (i_in.data_length != 8'd0);
                o_push.valid = 1'b1;
                o_push.entry.is_hdr = 1'b1;
                o_push.entry.cmd = i_in.command;
                o_push.entry.seq_byte = seq_byte;
                o_push.entry.b3 = i_in.data_length;
                o_push.entry.close = (i_in.data_length == 8'd0);
                o_push.entry.seq7 = seq_byte[6:0];
            end else if (r_open) begin
                n_remaining = r_remaining - 8'd1;
                n_open = (r_remaining != 8'd1);
                o_push.valid = 1'b1;
                o_push.entry.is_hdr = 1'b0;
                o_push.entry.b3 = i_in.data_byte;
                o_push.entry.close = (r_remaining == 8'd1);
                o_push.entry.seq7 = r_frame_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_req <= sfb_pkg::REQ_NUM_FIRST;
            r_remaining <= 8'd0;
            r_open <= 1'b0;
            r_frame_seq <= 7'd0;
        end else begin
            r_next_req <= n_next_req;
            r_remaining <= n_remaining;
            r_open <= n_open;
            r_frame_seq <= n_frame_seq;
        end
    end

endmodule

FILE: rtl/sfb_queue.sv
`timescale 1ns / 1ps

module sfb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sfb_pkg::t_push  i_push,
    input  logic            i_pop,
    output sfb_pkg::t_qstat o_qstat,
    output sfb_pkg::t_cmd   o_entry
);

    sfb_pkg::t_cmd          r_mem [sfb_pkg::QDEPTH];
    logic [sfb_pkg::QAW-1:0] r_wp;
    logic [sfb_pkg::QAW-1:0] r_rp;
    logic [sfb_pkg::QAW:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_qstat.valid = (r_cnt != '0);
    assign o_qstat.full = (r_cnt == (sfb_pkg::QAW+1)'(sfb_pkg::QDEPTH));
    assign o_entry = r_mem[r_rp];
    assign do_push = i_push.valid && !o_qstat.full;
    assign do_pop = i_pop && o_qstat.valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/sfb_back.sv
`timescale 1ns / 1ps

module sfb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sfb_cfg_if.sink         i_cfg,
    input  sfb_pkg::t_qstat i_qstat,
    input  sfb_pkg::t_cmd   i_entry,
    output logic            o_pop,
    sfb_out_if.source       o_out
);

    typedef enum logic [2:0] {
        ST_PID,
        ST_CMD,
        ST_SEQ,
        ST_LEN,
        ST_CHK,
        ST_END
    } t_step;

    t_step         r_step;
    t_step         n_step;
    sfb_pkg::t_cmd r_cur;
    logic          r_busy;
    logic [7:0]    r_sum;
    logic [7:0]    n_sum;
    logic [7:0]    r_pid;
    logic [7:0]    r_end;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_run_last;
    logic          r_frame_last;
    logic [6:0]    r_req_num;

    logic       out_free;
    logic       emit;
    logic       last;
    logic [7:0] cur_byte;

    assign i_cfg.ready = 1'b1;
    assign out_free = !r_out_valid || o_out.ready;
    assign emit = r_busy && out_free;
    assign last = r_cur.close ? (r_step == ST_END) : (r_step == ST_LEN);
    assign o_pop = i_qstat.valid && (!r_busy || (emit && last));

    assign o_out.valid = r_out_valid;
    assign o_out.frame_byte = r_out_byte;
    assign o_out.run_last = r_run_last;
    assign o_out.frame_last = r_frame_last;
    assign o_out.request_number = r_req_num;

    always_comb begin
        cur_byte = r_end;
        n_sum = r_sum;
        n_step = ST_PID;
        case (r_step)
            ST_PID: begin
                cur_byte = r_pid;
                n_sum = r_pid;
                n_step = ST_CMD;
            end
            ST_CMD: begin
                cur_byte = r_cur.cmd;
                n_sum = r_sum + r_cur.cmd;
                n_step = ST_SEQ;
            end
            ST_SEQ: begin
                cur_byte = r_cur.seq_byte;
                n_sum = r_sum + r_cur.seq_byte;
                n_step = ST_LEN;
            end
            ST_LEN: begin
                cur_byte = r_cur.b3;
                n_sum = r_sum + r_cur.b3;
                n_step = ST_CHK;
            end
            ST_CHK: begin
                cur_byte = ~r_sum + 8'd1;
                n_step = ST_END;
            end
            default: begin
                cur_byte = r_end;
                n_step = ST_PID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_PID;
            r_busy <= 1'b0;
            r_sum <= 8'd0;
            r_pid <= 8'd0;
            r_end <= 8'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == sfb_pkg::REG_PROCESS_ID) begin
                    r_pid <= i_cfg.data;
                end else if (i_cfg.index == sfb_pkg::REG_END_MARKER) begin
                    r_end <= i_cfg.data;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
                r_out_byte <= cur_byte;
                r_run_last <= last;
                r_frame_last <= (r_step == ST_END);
                r_req_num <= r_cur.seq7;
                r_sum <= n_sum;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cur <= i_entry;
                r_step <= i_entry.is_hdr ? ST_PID : ST_LEN;
            end else if (emit) begin
                r_step <= n_step;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: rtl/serial_frame_builder_core.sv
`timescale 1ns / 1ps

// Serial frame builder. Each accepted word on i_in is classified at once and queued
// (four entries); the output side sends one frame byte per cycle while o_out is ready,
// from a registered byte stage. A header word yields 4 bytes (process id, command,
// sequence, length), or 6 when the length is zero (checksum and end marker added); a
// payload word yields 1 byte, or 3 when it is the last one of its frame; a payload
// word outside an open frame is taken and yields nothing. Sustained rate is one output
// byte per cycle while o_out is ready; input words are taken back to back while the
// queue has room. i_cfg is always ready (index 0 process id, index 1 end marker).

module serial_frame_builder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sfb_in_if.sink    i_in,
    sfb_cfg_if.sink   i_cfg,
    sfb_out_if.source o_out
);

    sfb_pkg::t_push  push;
    sfb_pkg::t_qstat qstat;
    sfb_pkg::t_cmd   entry;
    logic            pop;

    sfb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push)
    );

    sfb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_entry (entry)
    );

    sfb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_qstat (qstat),
        .i_entry (entry),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

FILE: tb/sv/tb_serial_frame_builder_core.sv
`timescale 1ns / 1ps

module tb_serial_frame_builder_core;
    import sfb_pkg::*;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       run_last;
        logic       frame_last;
        logic [6:0] request_number;
    } frame_word_t;

    class frame_byte_tracker;
        logic [7:0]  process_id;
        logic [7:0]  end_marker;
        logic [6:0]  next_request;
        logic [7:0]  running_sum;
        logic [7:0]  remaining;
        logic        frame_busy;
        logic [6:0]  frame_seq;
        frame_word_t pending[$];
        int          mismatches;

        function new();
            process_id = 8'h00;
            end_marker = 8'h00;
            next_request = REQ_NUM_FIRST;
            running_sum = 8'h00;
            remaining = 8'h00;
            frame_busy = 1'b0;
            frame_seq = 7'h00;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
            if (idx == REG_PROCESS_ID) process_id = value;
            else if (idx == REG_END_MARKER) end_marker = value;
        endfunction

        function void push_byte(logic [7:0] b, logic last_of_frame, logic counts);
            frame_word_t w;
            w.frame_byte = b;
            w.run_last = 1'b0;
            w.frame_last = last_of_frame;
            w.request_number = frame_seq;
            if (counts) running_sum = running_sum + b;
            pending.push_back(w);
        endfunction

        function void close_frame();
            push_byte(8'h00 - running_sum, 1'b0, 1'b0);
            push_byte(end_marker, 1'b1, 1'b0);
            frame_busy = 1'b0;
            remaining = 8'h00;
        endfunction

        function void note_word(logic op, logic is_req, logic [6:0] reply,
                                logic [7:0] cmd, logic [7:0] len, logic [7:0] db);
            logic [7:0] seq_byte;
            int         before_count;
            before_count = pending.size();
            if (op == OP_HEADER) begin
                if (is_req) begin
                    seq_byte = SEQ_REQ_FLAG | {1'b0, next_request};
                    next_request = next_request + 7'd1;
                    if (next_request == 7'd0) next_request = REQ_NUM_FIRST;
                end else begin
                    seq_byte = {1'b0, reply};
                end
                frame_seq = seq_byte[6:0];
                running_sum = 8'h00;
                push_byte(process_id, 1'b0, 1'b1);
                push_byte(cmd, 1'b0, 1'b1);
                push_byte(seq_byte, 1'b0, 1'b1);
                push_byte(len, 1'b0, 1'b1);
                if (len == 8'h00) begin
                    close_frame();
                end else begin
                    frame_busy = 1'b1;
                    remaining = len;
                end
            end else begin
                if (!frame_busy) return;
                push_byte(db, 1'b0, 1'b1);
                remaining = remaining - 8'd1;
                if (remaining == 8'h00) close_frame();
            end
            if (pending.size() > before_count) pending[pending.size() - 1].run_last = 1'b1;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= 30) $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_word(frame_word_t got);
            frame_word_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected byte %02h", got.frame_byte));
                return;
            end
            want = pending.pop_front();
            if (got.frame_byte !== want.frame_byte)
                report($sformatf("frame_byte %02h, want %02h", got.frame_byte, want.frame_byte));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last %b, want %b", got.run_last, want.run_last));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last %b, want %b", got.frame_last, want.frame_last));
            if (got.request_number !== want.request_number)
                report($sformatf("request_number %02h, want %02h",
                                 got.request_number, want.request_number));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    sfb_in_if  in_bus();
    sfb_cfg_if cfg_bus();
    sfb_out_if out_bus();

    serial_frame_builder_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .i_cfg  (cfg_bus),
        .o_out  (out_bus)
    );

    frame_byte_tracker tracker;
    bit  steady_flow;
    int  sink_stall;
    int  payload_words;
    int  request_headers;
    int  phase_words;

    always #6 i_clk = ~i_clk;

    function automatic int pick_send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(13, 40);
    endfunction

    function automatic int pick_sink_stall();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    always @(negedge i_clk) begin
        if (steady_flow) begin
            out_bus.ready <= 1'b1;
            sink_stall = 0;
        end else if (sink_stall > 0) begin
            out_bus.ready <= 1'b0;
            sink_stall--;
        end else begin
            out_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_stall = pick_sink_stall();
        end
    end

    always @(posedge i_clk) begin
        frame_word_t got;
        if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            got.frame_byte = out_bus.frame_byte;
            got.run_last = out_bus.run_last;
            got.frame_last = out_bus.frame_last;
            got.request_number = out_bus.request_number;
            tracker.check_word(got);
        end
    end

    task automatic send_word(input logic op, input logic is_req, input logic [6:0] reply,
                             input logic [7:0] cmd, input logic [7:0] len,
                             input logic [7:0] db);
        int gap;
        gap = steady_flow ? 0 : pick_send_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid <= 1'b1;
        in_bus.operation <= op;
        in_bus.is_request <= is_req;
        in_bus.reply_number <= reply;
        in_bus.command <= cmd;
        in_bus.data_length <= len;
        in_bus.data_byte <= db;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        if (op == OP_HEADER && is_req) request_headers++;
        if (op == OP_HEADER || tracker.frame_busy) phase_words++;
        tracker.note_word(op, is_req, reply, cmd, len, db);
    endtask

    task automatic send_header(input logic is_req, input logic [6:0] reply,
                               input logic [7:0] cmd, input logic [7:0] len);
        send_word(OP_HEADER, is_req, reply, cmd, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] db);
        send_word(OP_DATA, 1'($urandom), 7'($urandom), 8'($urandom), 8'($urandom), db);
    endtask

    task automatic await_results();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= value;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        tracker.set_register(idx, value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic random_frame(input bit full_length);
        logic [7:0] len;
        int         sends;
        int         r;
        if (!tracker.frame_busy && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 2)) send_payload(8'($urandom));
        r = $urandom_range(0, 99);
        if (full_length) len = 8'd255;
        else if (r < 35) len = 8'd0;
        else if (r < 75) len = 8'($urandom_range(1, 3));
        else if (r < 93) len = 8'($urandom_range(4, 16));
        else len = 8'($urandom_range(17, 255));
        sends = len;
        if (!full_length && len != 0
                && ($urandom_range(0, 9) == 0 || (len > 16 && $urandom_range(0, 9) < 7)))
            sends = $urandom_range(0, (len - 1 < 8) ? len - 1 : 8);
        send_header($urandom_range(0, 3) != 0, 7'($urandom), 8'($urandom), len);
        repeat (sends) send_payload(8'($urandom));
        if ($urandom_range(0, 39) == 0) await_results();
    endtask

    initial begin
        int phase;
        tracker = new();
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        steady_flow = 1'b0;
        sink_stall = 0;
        request_headers = 0;
        phase_words = 0;
        in_bus.valid = 1'b0;
        in_bus.operation = OP_HEADER;
        in_bus.is_request = 1'b0;
        in_bus.reply_number = 7'h00;
        in_bus.command = 8'h00;
        in_bus.data_length = 8'h00;
        in_bus.data_byte = 8'h00;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_PROCESS_ID;
        cfg_bus.data = 8'h00;
        out_bus.ready = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_payload(8'hff);
        send_word(OP_HEADER, 1'b0, 7'h00, 8'h00, 8'h00, 8'hff);
        send_word(OP_HEADER, 1'b1, 7'h7f, 8'hff, 8'h00, 8'h00);
        send_header(1'b0, 7'h7f, 8'ha5, 8'h01);
        send_payload(8'h00);
        send_header(1'b1, 7'h00, 8'h3c, 8'h02);
        send_payload(8'hff);
        send_payload(8'h00);
        send_payload(8'h5a);
        send_header(1'b1, 7'h2a, 8'h81, 8'hff);
        send_payload(8'h12);
        send_payload(8'h34);
        send_header(1'b0, 7'h55, 8'h7e, 8'h03);
        send_payload(8'h00);
        send_payload(8'hff);
        send_payload(8'h80);
        send_word(OP_HEADER, 1'b0, 7'h01, 8'h01, 8'h00, 8'h00);

        phase = 0;
        while (phase < 6) begin
            await_results();
            repeat (40) @(posedge i_clk);
            case (phase)
                0: begin
                    write_register(REG_PROCESS_ID, 8'hff);
                    write_register(REG_END_MARKER, 8'h00);
                end
                1: begin
                    write_register(REG_PROCESS_ID, 8'h00);
                    write_register(REG_END_MARKER, 8'hff);
                end
                2: begin
                    write_register(REG_PROCESS_ID, 8'hff);
                    write_register(REG_END_MARKER, 8'hff);
                end
                4: write_register(REG_END_MARKER, 8'($urandom));
                default: begin
                    write_register(REG_PROCESS_ID, 8'($urandom));
                    write_register(REG_END_MARKER, 8'($urandom));
                end
            endcase
            steady_flow = (phase % 3 == 1);
            phase_words = 0;
            if (phase == 2) begin
                while (request_headers < 130)
                    send_header(1'b1, 7'($urandom), 8'($urandom), 8'd0);
            end
            while (phase_words < 60) random_frame(1'b0);
            phase++;
        end

        steady_flow = 1'b0;
        await_results();
        repeat (40) @(posedge i_clk);
        if (tracker.pending.size() != 0)
            tracker.report($sformatf("%0d bytes never arrived", tracker.pending.size()));
        if (tracker.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #12000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
